// ===== rtl/cn2d_pkg.sv =====
// Package for the 2D collision normal unit: port structs, queue entry,
// fixed widths. No dependencies.
package cn2d_pkg;

  localparam int CW = 32;          // coordinate width
  localparam int SW = CW - 1;      // size width
  localparam int VW = CW + 3;      // difference vector width (doubled coords)
  localparam int NT = 30;          // normalized magnitude width
  localparam int LW = 2 * NT + 2;  // sum of squares width
  localparam int RW = NT + 1;      // root width
  localparam int SQ_STEPS = RW;    // one root bit per stage
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  typedef struct packed {
    logic                 shape_a;
    logic signed [CW-1:0] pos_ax;
    logic signed [CW-1:0] pos_ay;
    logic signed [CW-1:0] pos_az;
    logic [SW-1:0]        size_aw;
    logic [SW-1:0]        size_ah;
    logic                 shape_b;
    logic signed [CW-1:0] pos_bx;
    logic signed [CW-1:0] pos_by;
    logic signed [CW-1:0] pos_bz;
    logic [SW-1:0]        size_bw;
    logic [SW-1:0]        size_bh;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               degenerate;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } rsp_t;

  typedef struct packed {
    logic                 hit;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [VW-1:0] vz;
  } qent_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic hit;
    logic zero;
    logic sx;
    logic sy;
    logic sz;
  } meta_t;

endpackage

// ===== rtl/collision_normal_2d_unit.sv =====
// Top level of the 2D collision normal unit: front end, queue, back end.
// Depends on cn2d_pkg, cn2d_front, cn2d_fifo, cn2d_back.
//
//   channel   signals                     direction
//   request   req_valid, req_ready, req   in
//   response  rsp_valid, rsp_ready, rsp   out
//
// One request per cycle sustained while rsp_ready stays high.
// Synchronous reset clears all valid flags and the queue pointers.
// A stalled response freezes the back end; the queue absorbs the front end's
// in-flight requests before req_ready drops.
module collision_normal_2d_unit #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  cn2d_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cn2d_pkg::rsp_t rsp
);
  import cn2d_pkg::*;

  logic push, pop;
  qent_t push_ent, head;
  qstat_t qstat;

  cn2d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .push_ok  (!qstat.full || pop),
    .push     (push),
    .push_ent (push_ent)
  );

  cn2d_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(push_ent),
    .pop  (pop),
    .rdata(head),
    .stat (qstat)
  );

  cn2d_back #(.NFB(NORMAL_FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

// ===== rtl/cn2d_front.sv =====
// Front end: registers the request, runs the contact test and forms the
// difference vector. Depends on cn2d_pkg.
module cn2d_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  cn2d_pkg::req_t  req,
  input  logic            push_ok,
  output logic            push,
  output cn2d_pkg::qent_t push_ent
);
  import cn2d_pkg::*;

  logic en;
  logic v0, v1, v2;
  req_t r0;

  // stage 1
  logic cr1, csa1;
  logic signed [VW-1:0] dx1, dy1;
  logic signed [CW:0] d1 [3];
  logic [CW-1:0] s1;
  logic [SW-1:0] cw1, ch1;

  // stage 2
  logic cr2, hc2;
  logic signed [VW-1:0] vcx2, vcy2;
  logic signed [CW:0] d2 [3];
  logic [2*CW+1:0] sq2 [3];
  logic [2*CW-1:0] ss2;

  assign en = !(v2 && !push_ok);
  assign req_ready = en;
  assign push = v2 && push_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= req_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) r0 <= req;
  end

  // circle against rectangle, doubled coordinates
  logic signed [CW-1:0] c_x, c_y, q_x, q_y;
  logic [SW-1:0] rw, rh;
  logic signed [VW-1:0] cx, cy, lox, hix, loy, hiy, kx, ky;

  always_comb begin
    c_x = r0.shape_a ? r0.pos_ax : r0.pos_bx;
    c_y = r0.shape_a ? r0.pos_ay : r0.pos_by;
    q_x = r0.shape_a ? r0.pos_bx : r0.pos_ax;
    q_y = r0.shape_a ? r0.pos_by : r0.pos_ay;
    rw  = r0.shape_a ? r0.size_bw : r0.size_aw;
    rh  = r0.shape_a ? r0.size_bh : r0.size_ah;
    cx  = $signed({{(VW-CW-1){c_x[CW-1]}}, c_x, 1'b0});
    cy  = $signed({{(VW-CW-1){c_y[CW-1]}}, c_y, 1'b0});
    lox = $signed({{(VW-CW-1){q_x[CW-1]}}, q_x, 1'b0}) - $signed({{(VW-SW){1'b0}}, rw});
    hix = $signed({{(VW-CW-1){q_x[CW-1]}}, q_x, 1'b0}) + $signed({{(VW-SW){1'b0}}, rw});
    loy = $signed({{(VW-CW-1){q_y[CW-1]}}, q_y, 1'b0}) - $signed({{(VW-SW){1'b0}}, rh});
    hiy = $signed({{(VW-CW-1){q_y[CW-1]}}, q_y, 1'b0}) + $signed({{(VW-SW){1'b0}}, rh});
    kx  = (cx < lox) ? lox : ((cx > hix) ? hix : cx);
    ky  = (cy < loy) ? loy : ((cy > hiy) ? hiy : cy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr1  <= r0.shape_a != r0.shape_b;
      csa1 <= r0.shape_a;
      dx1  <= cx - kx;
      dy1  <= cy - ky;
      d1[0] <= $signed({r0.pos_ax[CW-1], r0.pos_ax}) - $signed({r0.pos_bx[CW-1], r0.pos_bx});
      d1[1] <= $signed({r0.pos_ay[CW-1], r0.pos_ay}) - $signed({r0.pos_by[CW-1], r0.pos_by});
      d1[2] <= $signed({r0.pos_az[CW-1], r0.pos_az}) - $signed({r0.pos_bz[CW-1], r0.pos_bz});
      s1   <= {1'b0, r0.size_aw} + {1'b0, r0.size_bh};
      cw1  <= r0.shape_a ? r0.size_aw : r0.size_bw;
      ch1  <= r0.shape_a ? r0.size_ah : r0.size_bh;
    end
  end

  logic [VW-1:0] mdx, mdy;
  logic [CW:0] dm [3];

  always_comb begin
    mdx = dx1[VW-1] ? VW'(-dx1) : VW'(dx1);
    mdy = dy1[VW-1] ? VW'(-dy1) : VW'(dy1);
    for (int i = 0; i < 3; i++) begin
      dm[i] = d1[i][CW] ? (CW+1)'(-d1[i]) : (CW+1)'(d1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr2  <= cr1;
      hc2  <= (mdx <= {{(VW-SW){1'b0}}, cw1}) && (mdy <= {{(VW-SW){1'b0}}, ch1});
      vcx2 <= csa1 ? dx1 : -dx1;
      vcy2 <= csa1 ? dy1 : -dy1;
      for (int i = 0; i < 3; i++) begin
        d2[i]  <= d1[i];
        sq2[i] <= {{(CW+1){1'b0}}, dm[i]} * {{(CW+1){1'b0}}, dm[i]};
      end
      ss2  <= {{CW{1'b0}}, s1} * {{CW{1'b0}}, s1};
    end
  end

  // 4*dist^2 <= (aw + bh)^2
  logic [2*CW+3:0] sum;
  logic [2*CW+5:0] sum4;

  always_comb begin
    sum  = {2'b00, sq2[0]} + {2'b00, sq2[1]} + {2'b00, sq2[2]};
    sum4 = {sum, 2'b00};
    push_ent.hit = cr2 ? hc2 : (sum4 <= {6'd0, ss2});
    if (cr2) begin
      push_ent.vx = vcx2;
      push_ent.vy = vcy2;
      push_ent.vz = '0;
    end else begin
      push_ent.vx = $signed({{(VW-CW-1){d2[0][CW]}}, d2[0]});
      push_ent.vy = $signed({{(VW-CW-1){d2[1][CW]}}, d2[1]});
      push_ent.vz = $signed({{(VW-CW-1){d2[2][CW]}}, d2[2]});
    end
  end

endmodule

// ===== rtl/cn2d_fifo.sv =====
// Short queue between front and back ends, register array with one read
// port. Depends on cn2d_pkg.
module cn2d_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cn2d_pkg::qent_t  wdata,
  input  logic             pop,
  output cn2d_pkg::qent_t  rdata,
  output cn2d_pkg::qstat_t stat
);
  import cn2d_pkg::*;

  qent_t mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0] count;

  assign rdata = mem[rptr];
  assign stat.empty = count == '0;
  assign stat.full  = count == (QAW+1)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

// ===== rtl/cn2d_back.sv =====
// Back end: normalizing shift, sum of squares, pipelined square root and
// three pipelined dividers. Depends on cn2d_pkg.
module cn2d_back #(
  parameter int NFB = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  cn2d_pkg::qent_t  head,
  input  cn2d_pkg::qstat_t qstat,
  output logic             pop,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output cn2d_pkg::rsp_t   rsp
);
  import cn2d_pkg::*;

  localparam int QW = NFB + 1;
  localparam int NW = NT + 1 + NFB;
  localparam int QX = (NFB + 2 > 16) ? NFB + 2 : 16;

  logic en;
  assign en  = !rsp_valid || rsp_ready;
  assign pop = en && !qstat.empty;

  // b0: queue head
  logic b0_vld;
  qent_t b0;
  always_ff @(posedge clk) begin
    if (rst) b0_vld <= 1'b0;
    else if (en) b0_vld <= pop;
  end
  always_ff @(posedge clk) begin
    if (en) b0 <= head;
  end

  // b1: magnitudes and leading one of the largest
  logic [VW-1:0] m0 [3];
  logic [VW-1:0] mx;
  logic [5:0] lp;
  always_comb begin
    m0[0] = b0.vx[VW-1] ? VW'(-b0.vx) : VW'(b0.vx);
    m0[1] = b0.vy[VW-1] ? VW'(-b0.vy) : VW'(b0.vy);
    m0[2] = b0.vz[VW-1] ? VW'(-b0.vz) : VW'(b0.vz);
    mx = m0[0];
    if (m0[1] > mx) mx = m0[1];
    if (m0[2] > mx) mx = m0[2];
    lp = '0;
    for (int i = 0; i < VW; i++) begin
      if (mx[i]) lp = 6'(i);
    end
  end

  logic b1_vld;
  logic [VW-1:0] m1 [3];
  logic [5:0] p1;
  meta_t mt1;
  always_ff @(posedge clk) begin
    if (rst) b1_vld <= 1'b0;
    else if (en) b1_vld <= b0_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= m0;
      p1  <= lp;
      mt1 <= '{hit: b0.hit, zero: mx == '0, sx: b0.vx[VW-1], sy: b0.vy[VW-1],
               sz: b0.vz[VW-1]};
    end
  end

  // b2: bring the largest into [2^29, 2^30)
  localparam logic [5:0] TOP = 6'(NT - 1);
  logic b2_vld;
  logic [NT-1:0] m2 [3];
  meta_t mt2;
  logic [VW-1:0] sh [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = (p1 >= TOP) ? (m1[i] >> (p1 - TOP)) : (m1[i] << (TOP - p1));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) b2_vld <= 1'b0;
    else if (en) b2_vld <= b1_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) m2[i] <= sh[i][NT-1:0];
      mt2 <= mt1;
    end
  end

  // b3: squares
  logic b3_vld;
  logic [2*NT-1:0] sq3 [3];
  logic [NT-1:0] m3 [3];
  meta_t mt3;
  always_ff @(posedge clk) begin
    if (rst) b3_vld <= 1'b0;
    else if (en) b3_vld <= b2_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= {{NT{1'b0}}, m2[i]} * {{NT{1'b0}}, m2[i]};
      end
      m3  <= m2;
      mt3 <= mt2;
    end
  end

  // square root, one root bit per stage
  logic          sq_vld  [SQ_STEPS+1];
  logic [LW-1:0] sq_l2   [SQ_STEPS+1];
  logic [RW-1:0] sq_root [SQ_STEPS+1];
  logic [RW+2:0] sq_rem  [SQ_STEPS+1];
  logic [NT-1:0] sq_m    [SQ_STEPS+1][3];
  meta_t         sq_mt   [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (en) sq_vld[0] <= b3_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_l2[0]   <= {2'b00, sq3[0]} + {2'b00, sq3[1]} + {2'b00, sq3[2]};
      sq_root[0] <= '0;
      sq_rem[0]  <= '0;
      sq_m[0]    <= m3;
      sq_mt[0]   <= mt3;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [RW+2:0] rs, tr;
    always_comb begin
      rs = {sq_rem[k][RW:0], sq_l2[k][LW-1-2*k -: 2]};
      tr = {1'b0, sq_root[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else if (en) sq_vld[k+1] <= sq_vld[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rs >= tr) begin
          sq_rem[k+1]  <= rs - tr;
          sq_root[k+1] <= {sq_root[k][RW-2:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= rs;
          sq_root[k+1] <= {sq_root[k][RW-2:0], 1'b0};
        end
        sq_l2[k+1] <= sq_l2[k];
        sq_m[k+1]  <= sq_m[k];
        sq_mt[k+1] <= sq_mt[k];
      end
    end
  end

  // dividers: (m * 2^F + L/2) / L, one quotient bit per stage
  logic          dv_vld [QW+1];
  logic [RW-1:0] dv_len [QW+1];
  logic [RW-1:0] dv_rem [QW+1][3];
  logic [QW-1:0] dv_low [QW+1][3];
  logic [QW-1:0] dv_q   [QW+1][3];
  meta_t         dv_mt  [QW+1];

  logic [RW-1:0] lr;
  logic [NW-1:0] num [3];
  always_comb begin
    lr = sq_root[SQ_STEPS];
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, sq_m[SQ_STEPS][i], {NFB{1'b0}}} + NW'(lr >> 1);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (en) dv_vld[0] <= sq_vld[SQ_STEPS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dv_len[0] <= lr;
      dv_mt[0]  <= sq_mt[SQ_STEPS];
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= {1'b0, num[i][NW-1:QW]};
        dv_low[0][i] <= num[i][QW-1:0];
        dv_q[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv_vld[k+1] <= 1'b0;
      else if (en) dv_vld[k+1] <= dv_vld[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_len[k+1] <= dv_len[k];
        dv_mt[k+1]  <= dv_mt[k];
      end
    end
    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [RW:0] t, d;
      always_comb begin
        t = {dv_rem[k][j], dv_low[k][j][QW-1-k]};
        d = t - {1'b0, dv_len[k]};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (t >= {1'b0, dv_len[k]}) begin
            dv_rem[k+1][j] <= d[RW-1:0];
            dv_q[k+1][j]   <= {dv_q[k][j][QW-2:0], 1'b1};
          end else begin
            dv_rem[k+1][j] <= t[RW-1:0];
            dv_q[k+1][j]   <= {dv_q[k][j][QW-2:0], 1'b0};
          end
          dv_low[k+1][j] <= dv_low[k][j];
        end
      end
    end
  end

  // output register
  meta_t mo;
  logic nz;
  logic [QX-1:0] qx [3];
  logic [QX-1:0] nv [3];
  logic sg [3];
  always_comb begin
    mo = dv_mt[QW];
    nz = mo.hit && !mo.zero;
    sg[0] = mo.sx;
    sg[1] = mo.sy;
    sg[2] = mo.sz;
    for (int i = 0; i < 3; i++) begin
      qx[i] = QX'(dv_q[QW][i]);
      nv[i] = nz ? (sg[i] ? QX'(-qx[i]) : qx[i]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (en) rsp_valid <= dv_vld[QW];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.hit        <= mo.hit;
      rsp.degenerate <= mo.hit && mo.zero;
      rsp.normal_x   <= nv[0][15:0];
      rsp.normal_y   <= nv[1][15:0];
      rsp.normal_z   <= nv[2][15:0];
    end
  end

endmodule

// ===== tb/collision_normal_2d_unit_check.sv =====
// Checker for the 2D collision normal unit: predicts each response from the
// accepted request and compares it with the whole response. Depends on cn2d_pkg.
module collision_normal_2d_unit_check (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  cn2d_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  cn2d_pkg::rsp_t rsp,
  output int             fails,
  output int             pending,
  output int             hits,
  output int             degens
);
  import cn2d_pkg::*;

  localparam int FRAC = 14;

  rsp_t contact_q[$];

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic rsp_t contact_of(req_t q);
    rsp_t o;
    longint pa[3], pb[3], v[3];
    longint aw, ah, bw, bh, rw, rh, cw, ch, cx, cy, kx, ky, dx, dy, lo, hi;
    longint unsigned m[3], mx, len2, l, qv;
    logic [131:0] dsum, lim;
    logic sa, sb, hitv;
    o = '0;
    sa = q.shape_a;
    sb = q.shape_b;
    pa[0] = longint'(q.pos_ax); pa[1] = longint'(q.pos_ay); pa[2] = longint'(q.pos_az);
    pb[0] = longint'(q.pos_bx); pb[1] = longint'(q.pos_by); pb[2] = longint'(q.pos_bz);
    aw = longint'({1'b0, q.size_aw}); ah = longint'({1'b0, q.size_ah});
    bw = longint'({1'b0, q.size_bw}); bh = longint'({1'b0, q.size_bh});
    v[0] = 0; v[1] = 0; v[2] = 0;
    hitv = 1'b0;
    if (sa != sb) begin
      rw = sa ? bw : aw; rh = sa ? bh : ah;
      cw = sa ? aw : bw; ch = sa ? ah : bh;
      cx = 2 * (sa ? pa[0] : pb[0]);
      cy = 2 * (sa ? pa[1] : pb[1]);
      lo = 2 * (sa ? pb[0] : pa[0]) - rw; hi = lo + 2 * rw;
      kx = cx < lo ? lo : (cx > hi ? hi : cx);
      lo = 2 * (sa ? pb[1] : pa[1]) - rh; hi = lo + 2 * rh;
      ky = cy < lo ? lo : (cy > hi ? hi : cy);
      dx = cx - kx;
      dy = cy - ky;
      if (mag64(dx) <= longint'(cw) && mag64(dy) <= longint'(ch)) begin
        hitv = 1'b1;
        v[0] = sa ? dx : -dx;
        v[1] = sa ? dy : -dy;
      end
    end else begin
      dsum = '0;
      for (int i = 0; i < 3; i++) begin
        v[i] = pa[i] - pb[i];
        dsum = dsum + 132'(mag64(v[i])) * 132'(mag64(v[i]));
      end
      lim = 132'(aw + bh) * 132'(aw + bh);
      hitv = (dsum << 2) <= lim;
    end
    o.hit = hitv;
    if (hitv) begin
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = mag64(v[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        o.degenerate = 1'b1;
      end else begin
        while (mx >= (64'd1 << 30)) begin
          mx >>= 1;
          for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
          mx <<= 1;
          for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        l = root64(len2);
        for (int i = 0; i < 3; i++) begin
          qv = ((m[i] << FRAC) + (l >> 1)) / l;
          if (v[i] < 0) qv = -qv;
          if (i == 0) o.normal_x = qv[15:0];
          else if (i == 1) o.normal_y = qv[15:0];
          else o.normal_z = qv[15:0];
        end
      end
    end
    return o;
  endfunction

  initial begin
    fails = 0; pending = 0; hits = 0; degens = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        want = contact_of(req);
        contact_q = {contact_q, want};
        if (want.hit) hits++;
        if (want.degenerate) degens++;
      end
      if (rsp_valid && rsp_ready) begin
        if (contact_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected response %h", rsp);
        end else begin
          want = contact_q.pop_front();
          if (rsp !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: hit %b/%b degen %b/%b n %0d,%0d,%0d / %0d,%0d,%0d",
                       want.hit, rsp.hit, want.degenerate, rsp.degenerate,
                       want.normal_x, want.normal_y, want.normal_z,
                       rsp.normal_x, rsp.normal_y, rsp.normal_z);
          end
        end
      end
      pending <= contact_q.size();
    end
  end
endmodule

// ===== tb/collision_normal_2d_unit_test.sv =====
// Top of the 2D collision normal testbench: clock, reset, request and
// response traffic, verdict. Depends on cn2d_pkg, the unit and its checker.
module collision_normal_2d_unit_test;
  import cn2d_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  logic req_ready, rsp_valid;
  req_t req = '0;
  rsp_t rsp;
  int fails, pending, hits, degens;
  int sent = 0;
  bit squeeze = 0;
  bit done = 0;

  collision_normal_2d_unit dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  collision_normal_2d_unit_check chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .fails(fails), .pending(pending), .hits(hits), .degens(degens)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  function automatic req_t pair(logic sa, int ax, int ay, int az, int aw, int ah,
                                logic sb, int bx, int by, int bz, int bw, int bh);
    req_t q;
    q.shape_a = sa; q.pos_ax = ax; q.pos_ay = ay; q.pos_az = az;
    q.size_aw = aw[30:0]; q.size_ah = ah[30:0];
    q.shape_b = sb; q.pos_bx = bx; q.pos_by = by; q.pos_bz = bz;
    q.size_bw = bw[30:0]; q.size_bh = bh[30:0];
    return q;
  endfunction

  // fully random request, every bit of the struct filled
  function automatic req_t rand_req();
    logic [319:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(req_t)-1:0];
  endfunction

  // a pair placed near each other at a random scale, so contacts are common
  function automatic req_t near_pair();
    req_t q;
    int k;
    int unsigned mask;
    k = $urandom_range(0, 30);
    mask = (32'd1 << k) - 1;
    q = rand_req();
    q.pos_bx = q.pos_ax + $signed($urandom & mask) - $signed(mask >> 1);
    q.pos_by = q.pos_ay + $signed($urandom & mask) - $signed(mask >> 1);
    q.pos_bz = ($urandom_range(0, 3) == 0) ? q.pos_az : q.pos_az + ($urandom & mask);
    q.size_aw = 31'($urandom & (mask << 1 | 1));
    q.size_ah = 31'($urandom & (mask << 1 | 1));
    q.size_bw = 31'($urandom & (mask << 1 | 1));
    q.size_bh = 31'($urandom & (mask << 1 | 1));
    if ($urandom_range(0, 7) == 0) q.pos_bx = q.pos_ax;
    return q;
  endfunction

  task automatic send(req_t q);
    int g;
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent++;
    g = squeeze ? 0 : gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // response side: random stalls, one long hold-off while requests keep coming
  initial begin
    @(negedge rst);
    @(posedge clk);
    while (!done) begin
      if (squeeze) begin
        rsp_ready <= 1'b0;
        repeat (300) @(posedge clk);
        squeeze = 0;
      end
      rsp_ready <= 1'b1;
      if (sent > 1100 && sent < 1250) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
        rsp_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners
    send(pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(pair(1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    send(pair(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    send(pair(0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send(pair(1, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff,
              0, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff));
    send(pair(0, 32'h80000000, 32'h7fffffff, 5, 32'h7fffffff, 32'h7fffffff,
              1, 32'h7fffffff, 32'h80000000, 9, 32'h7fffffff, 32'h7fffffff));
    // circle centre inside rectangle: zero gap, degenerate
    send(pair(1, 100, 100, 0, 10, 10, 0, 100, 100, 0, 400, 400));
    send(pair(0, 0, 0, 0, 400, 400, 1, 50, -50, 3, 10, 10));
    // touching exactly at a corner, then at an edge, each followed by a just miss
    send(pair(1, 210, 210, 0, 20, 20, 0, 0, 0, 0, 400, 400));
    send(pair(1, 211, 210, 0, 20, 20, 0, 0, 0, 0, 400, 400));
    send(pair(0, 0, 0, 0, 400, 400, 1, -210, 0, 0, 20, 20));
    send(pair(0, 0, 0, 0, 400, 400, 1, -211, 0, 0, 20, 20));
    // same shapes: exact touch, one past, z only
    send(pair(1, 0, 0, 0, 6, 0, 1, 3, 4, 0, 0, 4));
    send(pair(1, 0, 0, 0, 6, 0, 1, 3, 4, 1, 0, 4));
    send(pair(0, 0, 0, 7, 20, 20, 0, 0, 0, -3, 20, 20));
    send(pair(0, 1, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0));
    send(pair(1, -1, -1, -1, 32'h7fffffff, 0, 1, 0, 0, 0, 0, 32'h7fffffff));
    send(pair(0, 32'h12345678, -5, 0, 0, 0, 0, 32'h12345678, -5, 0, 0, 0));
    send(pair(1, 0, 0, 0, 1, 1, 0, 1, 1, 0, 0, 0));
    send(pair(0, 1, 1, 0, 0, 0, 1, 0, 0, 0, 1, 1));
    for (int i = 0; i < 1530; i++) begin
      if (i == 400) squeeze = 1;
      if ($urandom_range(0, 3) == 0)
        send(rand_req());
      else
        send(near_pair());
    end
    req_valid <= 1'b0;
    // let the checker's count take in the last accepted request
    @(posedge clk);
    @(posedge clk);
    while (pending != 0 || squeeze) @(posedge clk);
    repeat (80) @(posedge clk);
    done = 1;
    $display("covered %0d requests, %0d with contact, %0d degenerate", sent, hits, degens);
    $display("included a 300-cycle response hold-off with requests backed up");
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d responses missing", fails, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
